// ===== design/tcw_pkg.sv =====
// Shared types and constants of the text console character writer.
`default_nettype none

package tcw_pkg;

    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CHAR_W  = 8;
    localparam int CELL_W  = 16;
    localparam int COLOR_W = 4;
    localparam int IDX_W   = 11;
    localparam int POS_W   = 11;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = COLOR_W;

    localparam logic [CELL_W-1:0]  BLANK_CELL = 16'h0700;
    localparam logic [CHAR_W-1:0]  CODE_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0]  CODE_CR    = 8'h0D;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 1'b1;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'h7;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

    typedef struct packed {
        logic [COLOR_W-1:0] bg;
        logic [COLOR_W-1:0] fg;
    } attr_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_BLANK,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== design/tcw_screen_ram.sv =====
// Screen cell memory: one write port and one read port with registered read data.
`default_nettype none

module tcw_screen_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  wire logic                      aclk,
    input  wire logic                      we,
    input  wire logic [AW-1:0]             waddr,
    input  wire logic [tcw_pkg::CELL_W-1:0] wdata,
    input  wire logic [AW-1:0]             raddr,
    output logic      [tcw_pkg::CELL_W-1:0] rdata
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem_array [DEPTH];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_array[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/tcw_ctrl.sv =====
// Sequencer: cursor, request handling, clearing and scroll passes, result register.
`default_nettype none

module tcw_ctrl #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int AW      = 11
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire tcw_pkg::attr_t              attr,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_opcode,
    input  wire logic [tcw_pkg::CHAR_W-1:0]  s_char_code,
    input  wire logic [tcw_pkg::IDX_W-1:0]   s_cell_index,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic      [tcw_pkg::CELL_W-1:0]  m_cell_value,
    output logic      [tcw_pkg::POS_W-1:0]   m_cursor_position,
    output logic                             mem_we,
    output logic      [AW-1:0]               mem_waddr,
    output logic      [tcw_pkg::CELL_W-1:0]  mem_wdata,
    output logic      [AW-1:0]               mem_raddr,
    input  wire logic [tcw_pkg::CELL_W-1:0]  mem_rdata
);
    import tcw_pkg::*;

    localparam int CELLS        = COLUMNS * ROWS;
    localparam int PW           = (AW > POS_W) ? AW : POS_W;
    localparam int CW           = (AW + 1 > IDX_W) ? AW + 1 : IDX_W;
    localparam int BLANK_BASE   = (ROWS - 1) * COLUMNS;
    localparam int SCROLL_START = (ROWS > 1) ? COLUMNS : 0;

    state_t state_reg, state_next;

    logic [AW-1:0]     sweep_reg, sweep_next;
    logic              wr_pend_reg, wr_pend_next;
    logic [AW-1:0]     wr_addr_reg, wr_addr_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              rd_ok_reg, rd_ok_next;
    logic [CELL_W-1:0] res_value_reg, res_value_next;
    logic              m_valid_reg, m_valid_next;
    logic [CELL_W-1:0] m_cell_value_reg;
    logic [POS_W-1:0]  m_cursor_position_reg;

    logic              accept;
    logic              is_lf, is_cr, printable;
    logic [COL_W:0]    col_inc;
    logic              wrap, advance, last_row, scroll;
    logic              sweep_last;
    logic              out_load;
    logic [PW-1:0]     pos_wide;
    logic              idx_ok;

    assign accept    = s_valid && (state_reg == ST_IDLE);
    assign is_lf     = (s_char_code == CODE_LF);
    assign is_cr     = (s_char_code == CODE_CR);
    assign printable = !is_lf && !is_cr;
    assign col_inc   = {1'b0, col_reg} + (COL_W + 1)'(1);
    assign wrap      = (col_inc == (COL_W + 1)'(COLUMNS));
    assign advance   = is_lf || (printable && wrap);
    assign last_row  = (row_reg == ROW_W'(ROWS - 1));
    // A move down from the last row shifts the screen up instead.
    assign scroll    = accept && (s_opcode == OP_WRITE) && advance && last_row;
    assign sweep_last = (sweep_reg == AW'(CELLS - 1));
    assign out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign pos_wide  = PW'(row_reg) * PW'(COLUMNS) + PW'(col_reg);
    assign idx_ok    = (CW'(s_cell_index) < CW'(CELLS));

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (sweep_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_opcode == OP_READ) begin
                        state_next = ST_READ;
                    end else if (scroll) begin
                        state_next = (ROWS > 1) ? ST_COPY : ST_BLANK;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_READ: state_next = ST_DONE;
            ST_COPY: begin
                if (sweep_last) state_next = ST_BLANK;
            end
            ST_BLANK: begin
                if (!wr_pend_reg && sweep_last) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Outputs toward the input channel and the memory.
    always_comb begin
        s_ready   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = sweep_reg;
        mem_wdata = BLANK_CELL;
        mem_raddr = sweep_reg;
        unique case (state_reg)
            ST_CLEAR: mem_we = 1'b1;
            ST_IDLE: begin
                s_ready   = 1'b1;
                mem_raddr = AW'(s_cell_index);
                if (accept && (s_opcode == OP_WRITE) && printable) begin
                    mem_we    = 1'b1;
                    mem_waddr = pos_wide[AW-1:0];
                    mem_wdata = {attr.bg, attr.fg, s_char_code};
                end
            end
            ST_BLANK: mem_we = !wr_pend_reg;
            ST_READ, ST_COPY, ST_DONE: begin
                mem_we = 1'b0;
            end
            default: mem_we = 1'b0;
        endcase
        // The copy pass writes each cell in the cycle after it was read.
        if (wr_pend_reg) begin
            mem_we    = 1'b1;
            mem_waddr = wr_addr_reg;
            mem_wdata = mem_rdata;
        end
    end

    // Datapath registers.
    always_comb begin
        sweep_next     = sweep_reg;
        wr_pend_next   = (state_reg == ST_COPY);
        wr_addr_next   = sweep_reg - AW'(COLUMNS);
        col_next       = col_reg;
        row_next       = row_reg;
        rd_ok_next     = rd_ok_reg;
        res_value_next = res_value_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_CLEAR: begin
                sweep_next = sweep_last ? '0 : sweep_reg + AW'(1);
            end
            ST_IDLE: begin
                if (accept) begin
                    res_value_next = '0;
                    rd_ok_next     = idx_ok;
                    if (s_opcode == OP_WRITE) begin
                        if (is_lf || is_cr || wrap) begin
                            col_next = '0;
                        end else begin
                            col_next = col_inc[COL_W-1:0];
                        end
                        if (advance && !last_row) begin
                            row_next = row_reg + ROW_W'(1);
                        end
                        if (scroll) begin
                            sweep_next = AW'(SCROLL_START);
                        end
                    end
                end
            end
            ST_READ: begin
                res_value_next = rd_ok_reg ? mem_rdata : '0;
            end
            ST_COPY: begin
                sweep_next = sweep_last ? AW'(BLANK_BASE) : sweep_reg + AW'(1);
            end
            ST_BLANK: begin
                if (!wr_pend_reg && !sweep_last) sweep_next = sweep_reg + AW'(1);
            end
            ST_DONE: begin
                if (out_load) m_valid_next = 1'b1;
            end
            default: sweep_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            sweep_reg   <= '0;
            wr_pend_reg <= 1'b0;
            col_reg     <= '0;
            row_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sweep_reg   <= sweep_next;
            wr_pend_reg <= wr_pend_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wr_addr_reg   <= wr_addr_next;
        rd_ok_reg     <= rd_ok_next;
        res_value_reg <= res_value_next;
        if (out_load) begin
            m_cell_value_reg      <= res_value_reg;
            m_cursor_position_reg <= pos_wide[POS_W-1:0];
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_cell_value      = m_cell_value_reg;
    assign m_cursor_position = m_cursor_position_reg;

endmodule

`default_nettype wire

// ===== design/text_console_char_writer.sv =====
// Writes one character or reads back one cell of a text screen (top level).
// A character, line feed or carriage return goes through ST_IDLE and ST_DONE, a cell
// read through ST_IDLE, ST_READ and ST_DONE; ST_DONE loads the result register once
// the output is free; one request at a time. A move down from the last row adds a
// scroll pass through the single screen memory: a copy pass (if ROWS > 1) moves the
// rows up one cell read per cycle, then a blank pass fills the last row. After reset
// a clearing pass blanks every cell with s_ready low; configuration writes are taken at any time.
`default_nettype none

module text_console_char_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tcw_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_opcode,
    input  wire logic [tcw_pkg::CHAR_W-1:0]     s_char_code,
    input  wire logic [tcw_pkg::IDX_W-1:0]      s_cell_index,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic      [tcw_pkg::CELL_W-1:0]     m_cell_value,
    output logic      [tcw_pkg::POS_W-1:0]      m_cursor_position
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    attr_t             attr_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg.fg <= FG_RESET;
            attr_reg.bg <= BG_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FOREGROUND: attr_reg.fg <= cfg_wdata[COLOR_W-1:0];
                REG_BACKGROUND: attr_reg.bg <= cfg_wdata[COLOR_W-1:0];
                default: attr_reg <= attr_reg;
            endcase
        end
    end

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .AW      (AW)
    ) u_ctrl (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .attr              (attr_reg),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_char_code       (s_char_code),
        .s_cell_index      (s_cell_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_cell_value      (m_cell_value),
        .m_cursor_position (m_cursor_position),
        .mem_we            (mem_we),
        .mem_waddr         (mem_waddr),
        .mem_wdata         (mem_wdata),
        .mem_raddr         (mem_raddr),
        .mem_rdata         (mem_rdata)
    );

    tcw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_screen_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// ===== design/tcw_checker.sv =====
// Port-level checks of the text console character writer and their binding.
`default_nettype none

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_valid,
    input wire logic                       s_ready,
    input wire logic                       m_valid,
    input wire logic                       m_ready,
    input wire logic [tcw_pkg::CELL_W-1:0] m_cell_value,
    input wire logic [tcw_pkg::POS_W-1:0]  m_cursor_position
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;

    // A held result keeps its contents until taken.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_cell_value)
                                   && $stable(m_cursor_position)))
        else $error("result changed while stalled");

    // The reported cursor lies on the screen (checked when the screen has fewer than 2048 cells).
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (CELLS < 2048)) |-> (32'(m_cursor_position) < CELLS))
        else $error("cursor position off screen");

    // Each accepted request keeps the block busy, with s_ready low, before another can be taken.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken on back-to-back cycles");

    // The clearing pass keeps requests out right after reset.
    a_clear_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> (!s_ready && !m_valid))
        else $error("block ready before screen was cleared");

endmodule

bind text_console_char_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_cell_value      (m_cell_value),
    .m_cursor_position (m_cursor_position)
);

`default_nettype wire
